/* rtl/uv_sphere_tessellator_assert.svh */
// ----------------------------------------------------------------------------
// UV sphere tessellator assertion macros
// Immediate-style wrappers around concurrent properties clocked by i_clk and
// disabled while i_rst_n is low. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_TESSELLATOR_ASSERT_SVH
`define UV_SPHERE_TESSELLATOR_ASSERT_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define UVST_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("uv_sphere_tessellator: assertion failed");

// antecedent implies consequent in the next cycle
`define UVST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("uv_sphere_tessellator: assertion failed");

`else

`define UVST_ASSERT_SAME(lbl, ante, cons)
`define UVST_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* rtl/uvst_pkg.sv */
// ----------------------------------------------------------------------------
// UV sphere tessellator package
// Field widths, sine coefficients, pipeline depths and register indexes.
// ----------------------------------------------------------------------------
package uvst_pkg;

    localparam int CNT_W   = 11;   // sector / stack count registers
    localparam int RAD_W   = 16;   // radius, unsigned Q8.8
    localparam int COL_W   = 8;    // colour components
    localparam int IDX_W   = 10;   // stack / sector index of a cell
    localparam int POS_W   = 17;   // signed Q8.8 position
    localparam int SLOT_W  = 3;    // corner slot
    localparam int PH_W    = 32;   // phase, 2^-32 turn
    localparam int Q30_W   = 31;   // unsigned Q30 magnitude up to 1.0
    localparam int SIN_W   = 32;   // signed Q30 sine / cosine
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MAX_DIV_DEF = 1024;

    localparam logic [Q30_W-1:0] Q30_ONE    = 31'h4000_0000;
    localparam logic [PH_W-1:0]  QUARTER_PH = 32'h4000_0000;

    // quarter-wave odd polynomial, Q30; Horner runs A9 then A7, A5, A3, A1
    localparam logic [Q30_W-1:0] SIN_A9 = 31'd172272;
    localparam logic [Q30_W-1:0] SIN_COEF [4] = '{
        31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
    };

    localparam int DIV_NUM_W  = 44;
    localparam int DIV_BPS    = 4;
    localparam int DIV_STAGES = DIV_NUM_W / DIV_BPS;
    localparam int SIN_LAT    = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS  = 3'd0,
        REG_SECTORS = 3'd1,
        REG_STACKS  = 3'd2,
        REG_RED     = 3'd3,
        REG_GREEN   = 3'd4,
        REG_BLUE    = 3'd5
    } t_reg_idx;

endpackage

/* rtl/uvst_div.sv */
// ----------------------------------------------------------------------------
// UV sphere tessellator pipelined divider
// Restoring division, BPS quotient bits per stage, one request per cycle
// while i_en is high. Returns the full quotient; caller holds i_den steady.
// ----------------------------------------------------------------------------
module uvst_div #(
    parameter int NUM_W = uvst_pkg::DIV_NUM_W,
    parameter int DEN_W = uvst_pkg::CNT_W,
    parameter int BPS   = uvst_pkg::DIV_BPS
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);

    localparam int STAGES = NUM_W / BPS;

    logic [DEN_W-1:0] r_rem [STAGES];
    logic [NUM_W-1:0] r_nq  [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [DEN_W-1:0] w_rem_in;
        logic [NUM_W-1:0] w_nq_in;
        logic [DEN_W-1:0] w_rem;
        logic [NUM_W-1:0] w_nq;
        logic [DEN_W:0]   w_try;

        if (s == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_nq_in  = i_num;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_nq_in  = r_nq[s-1];
        end

        // shift dividend bits out the top, quotient bits in the bottom
        always_comb begin
            w_rem = w_rem_in;
            w_nq  = w_nq_in;
            w_try = '0;
            for (int b = 0; b < BPS; b++) begin
                w_try = {w_rem, w_nq[NUM_W-1]};
                w_nq  = {w_nq[NUM_W-2:0], 1'b0};
                if (w_try >= {1'b0, i_den}) begin
                    w_try   = w_try - {1'b0, i_den};
                    w_nq[0] = 1'b1;
                end
                w_rem = w_try[DEN_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_rem;
                r_nq[s]  <= w_nq;
            end
        end
    end

    assign o_quo = r_nq[STAGES-1];

endmodule

/* rtl/uvst_sin.sv */
// ----------------------------------------------------------------------------
// UV sphere tessellator pipelined sine
// Quadrant fold, Horner odd polynomial in Q30, clamp and sign; at most one
// multiplier per stage, and a registered result.
// ----------------------------------------------------------------------------
module uvst_sin (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [uvst_pkg::PH_W-1:0]         i_phase,
    output logic signed [uvst_pkg::SIN_W-1:0] o_value
);

    localparam int QW = uvst_pkg::Q30_W;
    localparam int SW = uvst_pkg::SIN_W;
    localparam int PW = 2 * QW;

    logic [QW-1:0] r_t   [1:6];
    logic          r_neg [1:7];
    logic [QW-1:0] r_u   [2:5];
    logic [QW-1:0] r_r   [3:6];
    logic [SW-1:0] r_s;
    logic signed [SW-1:0] r_out;

    logic [QW-1:0] w_t0;
    logic [PW-1:0] w_usq;
    logic [PW-1:0] w_prod [3:6];
    logic [SW-1:0] w_r    [3:6];
    logic [PW-1:0] w_sprod;
    logic [QW-1:0] w_mag;

    // fold odd quadrants onto the rising quarter
    assign w_t0  = i_phase[30] ? (uvst_pkg::Q30_ONE - QW'(i_phase[29:0]))
                               : QW'(i_phase[29:0]);
    assign w_usq = PW'(r_t[1]) * PW'(r_t[1]);

    assign w_prod[3] = PW'(r_u[2]) * PW'(uvst_pkg::SIN_A9);
    assign w_r[3]    = SW'(uvst_pkg::SIN_COEF[0]) - w_prod[3][PW-1:30];
    for (genvar k = 4; k <= 6; k++) begin : g_horner
        assign w_prod[k] = PW'(r_u[k-1]) * PW'(r_r[k-1]);
        assign w_r[k]    = SW'(uvst_pkg::SIN_COEF[k-3]) - w_prod[k][PW-1:30];
    end

    assign w_sprod = PW'(r_t[6]) * PW'(r_r[6]);
    assign w_mag   = (r_s > SW'(uvst_pkg::Q30_ONE)) ? uvst_pkg::Q30_ONE : r_s[QW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t[1]   <= w_t0;
            r_neg[1] <= i_phase[31];
            for (int k = 2; k <= 6; k++) begin
                r_t[k] <= r_t[k-1];
            end
            for (int k = 2; k <= 7; k++) begin
                r_neg[k] <= r_neg[k-1];
            end
            r_u[2] <= w_usq[QW+29:30];
            for (int k = 3; k <= 5; k++) begin
                r_u[k] <= r_u[k-1];
            end
            for (int k = 3; k <= 6; k++) begin
                r_r[k] <= w_r[k][QW-1:0];
            end
            r_s   <= w_sprod[PW-1:30];
            r_out <= r_neg[7] ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
        end
    end

    assign o_value = r_out;

endmodule

/* rtl/uv_sphere_tessellator.sv */
// ----------------------------------------------------------------------------
// UV sphere tessellator
// Turns one latitude/longitude cell into up to two coloured triangles.
// ----------------------------------------------------------------------------
// A cell request (stack i, sector j) is taken in any cycle in which the output
// holding register is free or hands over its final vertex, so cells flow in
// back to back. The first vertex of a cell passes through an input register,
// an 11-stage divider for the four corner phases, a phase register, an
// 8-stage sine/cosine pipeline, four scaling stages and the output holding
// register, all of which hold while that register keeps a vertex. A cell
// then leaves the output as six vertices (three next to a pole), one vertex
// per cycle while m_axis_tready is high, so the output port sets the
// sustained rate. Cells outside the configured grid are dropped at the input
// but still take a pipeline slot. Reset values: radius 1.0, 36 sectors, 18
// stacks, white. Write the configuration only while no cell is in flight.
// ----------------------------------------------------------------------------
`include "uv_sphere_tessellator_assert.svh"

module uv_sphere_tessellator #(
    parameter int MAX_DIVISIONS = uvst_pkg::MAX_DIV_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [uvst_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [uvst_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // cell requests
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [23:0]                         s_axis_tdata,  // stack_index, sector_index
    // vertices
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [79:0]                         m_axis_tdata,  // pos_x, pos_y, pos_z, red, green, blue
    output logic [uvst_pkg::SLOT_W-1:0]         m_axis_tuser,  // corner_slot
    output logic                                m_axis_tlast   // last_of_cell
);

    localparam int CW  = uvst_pkg::CNT_W;
    localparam int RW  = uvst_pkg::RAD_W;
    localparam int KW  = uvst_pkg::IDX_W;
    localparam int PSW = uvst_pkg::POS_W;
    localparam int SLW = uvst_pkg::SLOT_W;
    localparam int PHW = uvst_pkg::PH_W;
    localparam int SNW = uvst_pkg::SIN_W;
    localparam int NW  = uvst_pkg::DIV_NUM_W;
    localparam int NT  = uvst_pkg::DIV_STAGES + 1 + uvst_pkg::SIN_LAT + 4;
    localparam int ZPW = RW + 1 + SNW;

    localparam logic [SLW-1:0] SLOT_UP_FIRST = 3'd0;
    localparam logic [SLW-1:0] SLOT_UP_MID   = 3'd1;
    localparam logic [SLW-1:0] SLOT_UP_LAST  = 3'd2;
    localparam logic [SLW-1:0] SLOT_LO_FIRST = 3'd3;
    localparam logic [SLW-1:0] SLOT_LO_MID   = 3'd4;
    localparam logic [SLW-1:0] SLOT_LO_LAST  = 3'd5;

    // corner index: bit 1 selects the lower stack row, bit 0 the next sector
    localparam logic [1:0] CORNER_C1 = 2'd0;
    localparam logic [1:0] CORNER_C2 = 2'd1;
    localparam logic [1:0] CORNER_C3 = 2'd2;
    localparam logic [1:0] CORNER_C4 = 2'd3;

    typedef struct packed {
        logic valid;
        logic upper;
        logic lower;
    } t_tag;

    function automatic logic signed [63:0] f_rnd(input logic signed [63:0] v,
                                                 input int unsigned sh);
        logic [63:0] mag;
        logic [63:0] res;
        mag = v[63] ? 64'(-v) : 64'(v);
        res = (mag + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(res) : $signed(res);
    endfunction

    // configuration
    logic [RW-1:0]             r_radius;
    logic [CW-1:0]             r_sector_count;
    logic [CW-1:0]             r_stack_count;
    logic [uvst_pkg::COL_W-1:0] r_red;
    logic [uvst_pkg::COL_W-1:0] r_green;
    logic [uvst_pkg::COL_W-1:0] r_blue;

    logic [CW-1:0] w_ns;
    logic [CW-1:0] w_nt;

    // pipeline
    logic          w_en;
    t_tag          r_tag [0:NT];
    logic [KW-1:0] r_i;
    logic [KW-1:0] r_j;
    logic [KW-1:0] w_i;
    logic [KW-1:0] w_j;
    logic          w_in_ok;
    logic          w_upper;
    logic          w_lower;

    logic [NW-1:0]  w_num [4];
    logic [CW-1:0]  w_den [4];
    logic [NW-1:0]  w_quo [4];
    logic [PHW-1:0] r_ph  [4];

    logic signed [SNW-1:0] w_sin [4];
    logic signed [SNW-1:0] w_cos [4];

    logic signed [ZPW-1:0] r_pring [2];
    logic signed [ZPW-1:0] r_pz    [2];
    logic signed [SNW-1:0] r_m1_cos [2];
    logic signed [SNW-1:0] r_m1_sin [2];
    logic signed [SNW-1:0] r_ring  [2];
    logic signed [PSW-1:0] r_m2_z  [2];
    logic signed [SNW-1:0] r_m2_cos [2];
    logic signed [SNW-1:0] r_m2_sin [2];
    logic signed [63:0]    r_px    [4];
    logic signed [63:0]    r_py    [4];
    logic signed [PSW-1:0] r_m3_z  [2];
    logic signed [PSW-1:0] r_x     [4];
    logic signed [PSW-1:0] r_y     [4];
    logic signed [PSW-1:0] r_m4_z  [2];

    // output holding register
    logic                  r_em_valid;
    logic                  r_em_lower;
    logic [SLW-1:0]        r_slot;
    logic signed [PSW-1:0] r_em_x [4];
    logic signed [PSW-1:0] r_em_y [4];
    logic signed [PSW-1:0] r_em_z [2];
    logic [1:0]            w_corner;
    logic                  w_last;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius       <= 16'd256;
            r_sector_count <= 11'd36;
            r_stack_count  <= 11'd18;
            r_red          <= 8'd255;
            r_green        <= 8'd255;
            r_blue         <= 8'd255;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                uvst_pkg::REG_RADIUS:  r_radius       <= i_cfg_data;
                uvst_pkg::REG_SECTORS: r_sector_count <= i_cfg_data[CW-1:0];
                uvst_pkg::REG_STACKS:  r_stack_count  <= i_cfg_data[CW-1:0];
                uvst_pkg::REG_RED:     r_red          <= i_cfg_data[7:0];
                uvst_pkg::REG_GREEN:   r_green        <= i_cfg_data[7:0];
                uvst_pkg::REG_BLUE:    r_blue         <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign w_ns = (32'(r_sector_count) > MAX_DIVISIONS) ? CW'(MAX_DIVISIONS) : r_sector_count;
    assign w_nt = (32'(r_stack_count) > MAX_DIVISIONS) ? CW'(MAX_DIVISIONS) : r_stack_count;

    // ------------------------------------------------------------------------
    // input stage: drop cells that emit nothing
    // ------------------------------------------------------------------------
    assign w_i     = s_axis_tdata[KW-1:0];
    assign w_j     = s_axis_tdata[2*KW-1:KW];
    assign w_upper = (w_i != '0);
    assign w_lower = ({1'b0, w_i} != w_nt - CW'(1));
    assign w_in_ok = ({1'b0, w_i} < w_nt) && ({1'b0, w_j} < w_ns) && (w_upper || w_lower);

    // whole pipeline advances unless the holding register keeps a vertex
    assign w_en          = !r_em_valid || (m_axis_tready && w_last);
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NT; k++) begin
                r_tag[k] <= '0;
            end
        end else if (w_en) begin
            r_tag[0] <= '{valid: s_axis_tvalid && w_in_ok, upper: w_upper, lower: w_lower};
            for (int k = 1; k <= NT; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_i <= w_i;
            r_j <= w_j;
        end
    end

    // ------------------------------------------------------------------------
    // corner phases: stack i, i+1 and sector j, j+1, rounded quotients
    // ------------------------------------------------------------------------
    assign w_num[0] = {2'b00, {1'b0, r_i},          31'(w_nt >> 1)};
    assign w_num[1] = {2'b00, {1'b0, r_i} + CW'(1), 31'(w_nt >> 1)};
    assign w_num[2] = {1'b0,  {1'b0, r_j},          32'(w_ns >> 1)};
    assign w_num[3] = {1'b0,  {1'b0, r_j} + CW'(1), 32'(w_ns >> 1)};
    assign w_den[0] = w_nt;
    assign w_den[1] = w_nt;
    assign w_den[2] = w_ns;
    assign w_den[3] = w_ns;

    for (genvar g = 0; g < 4; g++) begin : g_div
        uvst_div #(
            .NUM_W (NW),
            .DEN_W (CW),
            .BPS   (uvst_pkg::DIV_BPS)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (w_num[g]),
            .i_den (w_den[g]),
            .o_quo (w_quo[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ph[0] <= uvst_pkg::QUARTER_PH - w_quo[0][PHW-1:0];
            r_ph[1] <= uvst_pkg::QUARTER_PH - w_quo[1][PHW-1:0];
            r_ph[2] <= w_quo[2][PHW-1:0];
            r_ph[3] <= w_quo[3][PHW-1:0];
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_trig
        uvst_sin u_sin (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_phase (r_ph[g]),
            .o_value (w_sin[g])
        );
        uvst_sin u_cos (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_phase (r_ph[g] + uvst_pkg::QUARTER_PH),
            .o_value (w_cos[g])
        );
    end

    // ------------------------------------------------------------------------
    // scaling: ring radius and height per stack row, then x and y per corner
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s < 2; s++) begin
                r_pring[s]  <= $signed({1'b0, r_radius}) * w_cos[s];
                r_pz[s]     <= $signed({1'b0, r_radius}) * w_sin[s];
                r_m1_cos[s] <= w_cos[s+2];
                r_m1_sin[s] <= w_sin[s+2];

                r_ring[s]   <= SNW'(f_rnd(64'(r_pring[s]), 16));
                r_m2_z[s]   <= PSW'(f_rnd(64'(r_pz[s]), 30));
                r_m2_cos[s] <= r_m1_cos[s];
                r_m2_sin[s] <= r_m1_sin[s];

                r_m3_z[s]   <= r_m2_z[s];
                r_m4_z[s]   <= r_m3_z[s];
            end
            for (int k = 0; k < 4; k++) begin
                r_px[k] <= 64'(r_ring[k/2]) * 64'(r_m2_cos[k%2]);
                r_py[k] <= 64'(r_ring[k/2]) * 64'(r_m2_sin[k%2]);
                r_x[k]  <= PSW'(f_rnd(r_px[k], 44));
                r_y[k]  <= PSW'(f_rnd(r_py[k], 44));
            end
        end
    end

    // ------------------------------------------------------------------------
    // vertex emitter
    // ------------------------------------------------------------------------
    assign w_last = (r_slot == (r_em_lower ? SLOT_LO_LAST : SLOT_UP_LAST));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_valid <= 1'b0;
            r_em_lower <= 1'b0;
            r_slot     <= SLOT_UP_FIRST;
        end else if (w_en) begin
            r_em_valid <= r_tag[NT].valid;
            r_em_lower <= r_tag[NT].lower;
            r_slot     <= r_tag[NT].upper ? SLOT_UP_FIRST : SLOT_LO_FIRST;
        end else if (m_axis_tready) begin
            r_slot <= r_slot + SLW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_em_x <= r_x;
            r_em_y <= r_y;
            r_em_z <= r_m4_z;
        end
    end

    always_comb begin
        case (r_slot)
            SLOT_UP_FIRST: w_corner = CORNER_C1;
            SLOT_UP_MID:   w_corner = CORNER_C3;
            SLOT_UP_LAST:  w_corner = CORNER_C2;
            SLOT_LO_FIRST: w_corner = CORNER_C2;
            SLOT_LO_MID:   w_corner = CORNER_C3;
            SLOT_LO_LAST:  w_corner = CORNER_C4;
            default:       w_corner = CORNER_C1;
        endcase
    end

    assign m_axis_tvalid = r_em_valid;
    assign m_axis_tdata  = {5'b0, r_blue, r_green, r_red, r_em_z[w_corner[1]],
                            r_em_y[w_corner], r_em_x[w_corner]};
    assign m_axis_tuser  = r_slot;
    assign m_axis_tlast  = w_last;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `UVST_ASSERT_SAME(a_last_ends_triangle, m_axis_tvalid && m_axis_tlast,
        (m_axis_tuser == SLOT_UP_LAST) || (m_axis_tuser == SLOT_LO_LAST))
    `UVST_ASSERT_SAME(a_ready_when_empty, !r_em_valid, s_axis_tready)
    `UVST_ASSERT_NEXT(a_slot_advances, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
        m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + SLW'(1)))
    `UVST_ASSERT_NEXT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && !s_axis_tready || m_axis_tlast || m_axis_tvalid)

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// UV sphere tessellator testbench
// Drives cell requests and configuration writes, predicts every vertex with a
// fixed-point sphere model and checks the vertex stream in order, with random
// idling on both stream sides.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [uvst_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [uvst_pkg::POS_W-1:0]  x;
        logic [uvst_pkg::POS_W-1:0]  y;
        logic [uvst_pkg::POS_W-1:0]  z;
        logic [uvst_pkg::COL_W-1:0]  r;
        logic [uvst_pkg::COL_W-1:0]  g;
        logic [uvst_pkg::COL_W-1:0]  b;
        logic [uvst_pkg::SLOT_W-1:0] slot;
        logic                        last;
    } t_vertex;

    typedef struct packed {
        logic [uvst_pkg::IDX_W-1:0] stack;
        logic [uvst_pkg::IDX_W-1:0] sector;
    } t_cell;

    logic i_clk, i_rst_n;
    logic i_cfg_valid, o_cfg_ready;
    logic [uvst_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [uvst_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic s_axis_tvalid, s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic m_axis_tvalid, m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic [uvst_pkg::SLOT_W-1:0] m_axis_tuser;
    logic m_axis_tlast;

    uv_sphere_tessellator dut (.*);

    // sphere settings as the block should hold them
    logic [uvst_pkg::RAD_W-1:0] sph_radius;
    logic [uvst_pkg::CNT_W-1:0] sph_sectors, sph_stacks;
    logic [uvst_pkg::COL_W-1:0] sph_red, sph_green, sph_blue;

    t_cell   cell_q[$];
    t_vertex vertex_q[$];
    t_cell   cur_cell;
    logic    cell_taken;
    int      send_idle_pct, recv_stall_pct;
    int      n_errors, n_cells, n_vertices;

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    function automatic longint quarter_wave(longint unsigned t);
        longint unsigned u, acc, s;
        u   = (t * t) >> 30;
        acc = 172272;
        acc = 64'd5026995 - ((u * acc) >> 30);
        acc = 64'd85569306 - ((u * acc) >> 30);
        acc = 64'd693598668 - ((u * acc) >> 30);
        acc = 64'd1686629713 - ((u * acc) >> 30);
        s   = (t * acc) >> 30;
        return (s > 64'h4000_0000) ? 64'h4000_0000 : s;
    endfunction

    function automatic longint sine_of(logic [31:0] ph);
        longint unsigned t;
        longint m;
        t = ph[30] ? (64'h4000_0000 - ph[29:0]) : ph[29:0];
        m = quarter_wave(t);
        return ph[31] ? -m : m;
    endfunction

    function automatic longint cosine_of(logic [31:0] ph);
        return sine_of(ph + 32'h4000_0000);
    endfunction

    // round to nearest, halves away from zero
    function automatic longint round_off(longint v, int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v >= 0) return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    function automatic logic [31:0] longitude_phase(longint unsigned k, longint unsigned n);
        return 32'(((k << 32) + n / 2) / n);
    endfunction

    function automatic logic [31:0] latitude_phase(longint unsigned k, longint unsigned n);
        return 32'h4000_0000 - 32'(((k << 31) + n / 2) / n);
    endfunction

    task automatic add_vertex(longint x, longint y, longint z, int slot);
        t_vertex v;
        v.x = x[uvst_pkg::POS_W-1:0];
        v.y = y[uvst_pkg::POS_W-1:0];
        v.z = z[uvst_pkg::POS_W-1:0];
        v.r = sph_red; v.g = sph_green; v.b = sph_blue;
        v.slot = slot[uvst_pkg::SLOT_W-1:0];
        v.last = 1'b0;
        vertex_q.push_back(v);
    endtask

    task automatic tessellate_cell(t_cell c);
        longint unsigned ns, nt;
        longint rad, ring1, ring2, z1, z2, ca, sa, cb, sb;
        longint x1, y1, x2, y2, x3, y3, x4, y4;
        logic [31:0] p1, p2, pa, pb;
        int n;
        ns  = (sph_sectors > uvst_pkg::MAX_DIV_DEF) ? uvst_pkg::MAX_DIV_DEF : sph_sectors;
        nt  = (sph_stacks > uvst_pkg::MAX_DIV_DEF) ? uvst_pkg::MAX_DIV_DEF : sph_stacks;
        rad = sph_radius;
        n   = 0;
        if (c.stack >= nt || c.sector >= ns) return;
        p1 = latitude_phase(c.stack, nt);
        p2 = latitude_phase(c.stack + 1, nt);
        pa = longitude_phase(c.sector, ns);
        pb = longitude_phase(c.sector + 1, ns);
        ring1 = round_off(rad * cosine_of(p1), 16);
        ring2 = round_off(rad * cosine_of(p2), 16);
        z1 = round_off(rad * sine_of(p1), 30);
        z2 = round_off(rad * sine_of(p2), 30);
        ca = cosine_of(pa); sa = sine_of(pa);
        cb = cosine_of(pb); sb = sine_of(pb);
        x1 = round_off(ring1 * ca, 44); y1 = round_off(ring1 * sa, 44);
        x2 = round_off(ring1 * cb, 44); y2 = round_off(ring1 * sb, 44);
        x3 = round_off(ring2 * ca, 44); y3 = round_off(ring2 * sa, 44);
        x4 = round_off(ring2 * cb, 44); y4 = round_off(ring2 * sb, 44);
        if (c.stack != 0) begin
            add_vertex(x1, y1, z1, 0);
            add_vertex(x3, y3, z2, 1);
            add_vertex(x2, y2, z1, 2);
            n += 3;
        end
        if (c.stack != nt - 1) begin
            add_vertex(x2, y2, z1, 3);
            add_vertex(x3, y3, z2, 4);
            add_vertex(x4, y4, z2, 5);
            n += 3;
        end
        if (n > 0) vertex_q[$].last = 1'b1;
    endtask

    // request driver: advance on acceptance, idle at random
    always @(posedge i_clk) begin
        cell_taken <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready) begin
            n_cells++;
            tessellate_cell(cur_cell);
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || cell_taken)) begin
            if (cell_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_cell = cell_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {4'b0, cur_cell.sector, cur_cell.stack};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // vertex monitor
    always @(posedge i_clk) begin
        t_vertex got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[16:0], m_axis_tdata[33:17], m_axis_tdata[50:34],
                   m_axis_tdata[58:51], m_axis_tdata[66:59], m_axis_tdata[74:67],
                   m_axis_tuser, m_axis_tlast};
            n_vertices++;
            if (vertex_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("ERROR: unexpected vertex %h", got);
            end else begin
                want = vertex_q.pop_front();
                if (got !== want) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("ERROR: vertex mismatch exp x=%h y=%h z=%h rgb=%h%h%h slot=%0d last=%b",
                                 want.x, want.y, want.z, want.r, want.g, want.b,
                                 want.slot, want.last);
                        $display("       got x=%h y=%h z=%h rgb=%h%h%h slot=%0d last=%b",
                                 got.x, got.y, got.z, got.r, got.g, got.b,
                                 got.slot, got.last);
                    end
                end
            end
        end
    end

    task automatic write_reg(logic [uvst_pkg::CFG_IDX_W-1:0] idx,
                             logic [uvst_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            uvst_pkg::REG_RADIUS:  sph_radius  = val;
            uvst_pkg::REG_SECTORS: sph_sectors = val[uvst_pkg::CNT_W-1:0];
            uvst_pkg::REG_STACKS:  sph_stacks  = val[uvst_pkg::CNT_W-1:0];
            uvst_pkg::REG_RED:     sph_red     = val[uvst_pkg::COL_W-1:0];
            uvst_pkg::REG_GREEN:   sph_green   = val[uvst_pkg::COL_W-1:0];
            uvst_pkg::REG_BLUE:    sph_blue    = val[uvst_pkg::COL_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_sphere(int rad, int sec, int stk, int r, int g, int b);
        write_reg(uvst_pkg::REG_RADIUS, 16'(rad));
        write_reg(uvst_pkg::REG_SECTORS, 16'(sec));
        write_reg(uvst_pkg::REG_STACKS, 16'(stk));
        write_reg(uvst_pkg::REG_RED, 16'(r));
        write_reg(uvst_pkg::REG_GREEN, 16'(g));
        write_reg(uvst_pkg::REG_BLUE, 16'(b));
    endtask

    task automatic add_cell(int stk, int sec);
        t_cell c;
        c.stack  = uvst_pkg::IDX_W'(stk);
        c.sector = uvst_pkg::IDX_W'(sec);
        cell_q.push_back(c);
    endtask

    // hold until every request is taken and every vertex has come out
    task automatic drain(int mode);
        send_idle_pct  = (mode == 1 || mode == 3) ? 69 : 0;
        recv_stall_pct = (mode == 2) ? 69 : (mode == 3) ? 27 : 0;
        if (mode == 3) send_idle_pct = 27;
        while (cell_q.size() > 0 || s_axis_tvalid || vertex_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_cells(int count);
        int ns, nt;
        ns = (sph_sectors > uvst_pkg::MAX_DIV_DEF) ? uvst_pkg::MAX_DIV_DEF : sph_sectors;
        nt = (sph_stacks > uvst_pkg::MAX_DIV_DEF) ? uvst_pkg::MAX_DIV_DEF : sph_stacks;
        repeat (count) begin
            if ($urandom_range(99) < 85 && ns > 0 && nt > 0) begin
                case ($urandom_range(3))
                    0: add_cell(0, $urandom_range(ns - 1));
                    1: add_cell(nt - 1, $urandom_range(ns - 1));
                    default: add_cell($urandom_range(nt - 1), $urandom_range(ns - 1));
                endcase
            end else begin
                add_cell($urandom_range(1023), $urandom_range(1023));
            end
        end
    endtask

    initial begin
        #(8 * 2_000_000);
        $display("uv_sphere_tessellator verification failed");
        $finish;
    end

    initial begin
        int cnt_hi;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        m_axis_tready = 1'b1;
        cell_taken = 1'b0;
        send_idle_pct = 0; recv_stall_pct = 0;
        n_errors = 0; n_cells = 0; n_vertices = 0;
        sph_radius = 256; sph_sectors = 36; sph_stacks = 18;
        sph_red = 255; sph_green = 255; sph_blue = 255;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: poles, interior, cells just off the grid
        add_cell(0, 0); add_cell(17, 35); add_cell(1, 5); add_cell(9, 18);
        add_cell(18, 0); add_cell(0, 36); add_cell(1023, 1023);
        drain(0);

        // extreme radius and division counts, black
        set_sphere(65535, 1024, 1024, 0, 0, 0);
        write_reg(REG_UNUSED, 16'hffff);
        add_cell(0, 0); add_cell(1023, 1023); add_cell(512, 511); add_cell(1, 1022);
        drain(1);

        // counts beyond the limit saturate; zero radius
        set_sphere(0, 2047, 2047, 170, 85, 1);
        add_cell(1023, 0); add_cell(5, 1023);
        drain(2);

        // smallest grid, then a single stack and a zero count
        set_sphere(65535, 3, 2, 255, 0, 128);
        add_cell(0, 0); add_cell(1, 2); add_cell(2, 0); add_cell(0, 3);
        drain(3);
        write_reg(uvst_pkg::REG_STACKS, 16'd1);
        add_cell(0, 0); add_cell(0, 2);
        drain(0);
        write_reg(uvst_pkg::REG_SECTORS, 16'd0);
        add_cell(0, 0);
        drain(1);

        for (int ph = 0; ph < 12; ph++) begin
            cnt_hi = (ph % 3 == 0) ? 1024 : 64;
            set_sphere($urandom_range(65535), $urandom_range(3, cnt_hi),
                       $urandom_range(2, cnt_hi), $urandom_range(255),
                       $urandom_range(255), $urandom_range(255));
            random_cells(24);
            drain(ph % 4);
        end

        $display("Covered %0d cell requests and %0d vertices over 18 sphere settings",
                 n_cells, n_vertices);
        $display("Mismatches: %0d", n_errors);
        if (n_errors == 0) begin
            $display("uv_sphere_tessellator verification clean");
        end else begin
            $display("uv_sphere_tessellator verification failed");
        end
        $finish;
    end
endmodule
